[design/wms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wms_pkg: shared types and constants for the window median / std-dev block
// Field widths, request codes, result fill values and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package wms_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int LEN_BITS    = 6;
  localparam int RANK_BITS   = 5;
  localparam int MEDIAN_BITS = 13;
  localparam int STD_BITS    = 20;
  localparam int FRAC_BITS   = 16;

  localparam logic [LEN_BITS-1:0]           WINDOW_LEN_RESET = 6'd31;
  localparam logic signed [MEDIAN_BITS-1:0] MEDIAN_NONE      = -13'sd1;
  localparam logic signed [STD_BITS-1:0]    STD_NONE         = -20'sd256;

  // request codes
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_OLD,
    OP_NEW,
    OP_ACC,
    OP_RANK,
    OP_MHI,
    OP_MLO,
    OP_SQRT,
    OP_DIV,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic ram_rd;
  } dp_cmd_t;

  typedef struct packed {
    logic is_add;
    logic full;
    logic out_busy;
  } dp_status_t;

endpackage

[design/wms_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wms_ifs: valid/ready channels of the window median / std-dev block
// Input request, result and window-length write channels.
// ----------------------------------------------------------------------------
interface wms_in_if;
  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic [wms_pkg::SAMPLE_BITS-1:0]  sample;
  logic [wms_pkg::RANK_BITS-1:0]    rank;

  modport source (output valid, req_type, sample, rank, input ready);
  modport sink   (input valid, req_type, sample, rank, output ready);
endinterface

interface wms_out_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    full_res;
  logic signed [wms_pkg::MEDIAN_BITS-1:0]  median;
  logic signed [wms_pkg::STD_BITS-1:0]     std_dev;
  logic [wms_pkg::SAMPLE_BITS-1:0]         ranked_value;

  modport source (output valid, full_res, median, std_dev, ranked_value, input ready);
  modport sink   (input valid, full_res, median, std_dev, ranked_value, output ready);
endinterface

interface wms_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [wms_pkg::LEN_BITS-1:0]  window_len;

  modport source (output valid, window_len, input ready);
  modport sink   (input valid, window_len, output ready);
endinterface

[design/wms_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wms_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wms_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/wms_sort_row.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wms_sort_row: row of cells holding the window in ascending order
// Each cell compares against a key and shifts from a neighbor to delete one
// copy of the key or to insert the key at its sorted place.
// ----------------------------------------------------------------------------
module wms_sort_row #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             clr,
  input  logic                             del_en,
  input  logic                             ins_en,
  input  logic [WIDTH-1:0]                 key,
  input  logic [$clog2(DEPTH+1)-1:0]       len,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] cell_r   [DEPTH];
  logic [WIDTH-1:0] cell_nxt [DEPTH];
  logic [DEPTH-1:0] gt;

  // key compare per cell; cells from len-1 up count as above the key
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i] = (i >= int'(len) - 1) || (cell_r[i] > key);
    end
  end

  // shift left over the key's first copy, or shift right to open its slot
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_nxt[i] = cell_r[i];
      if (del_en && (i < int'(len) - 1) && (i < DEPTH - 1) && (cell_r[i] >= key)) begin
        cell_nxt[i] = cell_r[(i < DEPTH - 1) ? i + 1 : i];
      end
      if (ins_en && (i < int'(len)) && gt[i]) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          cell_nxt[i] = cell_r[(i > 0) ? i - 1 : 0];
        end else begin
          cell_nxt[i] = key;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (!rst_n || clr) begin
        cell_r[i] <= '0;
      end else begin
        cell_r[i] <= cell_nxt[i];
      end
    end
  end

  assign rd_data = cell_r[rd_addr];

endmodule

[design/wms_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wms_datapath: window store, running sums, sorted row and root/divide unit
// Executes one controller command per cycle and holds the result register.
// ----------------------------------------------------------------------------
module wms_datapath #(
  parameter int MAX_WINDOW = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [wms_pkg::LEN_BITS-1:0]         cfg_len,
  input  logic                                 in_req_type,
  input  logic [wms_pkg::SAMPLE_BITS-1:0]      in_sample,
  input  logic [wms_pkg::RANK_BITS-1:0]        in_rank,
  input  wms_pkg::dp_cmd_t                     cmd,
  output wms_pkg::dp_status_t                  status,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic                                 out_full_res,
  output logic signed [wms_pkg::MEDIAN_BITS-1:0] out_median,
  output logic signed [wms_pkg::STD_BITS-1:0]  out_std_dev,
  output logic [wms_pkg::SAMPLE_BITS-1:0]      out_ranked_value
);
  import wms_pkg::*;

  localparam int AW  = $clog2(MAX_WINDOW);
  localparam int LW  = $clog2(MAX_WINDOW + 1);
  localparam int SB  = SAMPLE_BITS;
  localparam int S1W = SB + LW;
  localparam int S2W = 2 * SB + LW;
  localparam int DW  = 2 * SB + 2 * LW;
  localparam int RW  = (DW + FRAC_BITS + 1) / 2;
  localparam int XW  = 2 * RW;
  localparam int PW  = S1W + S2W;

  logic [LEN_BITS-1:0] len_r;
  logic                req_r;
  logic [SB-1:0]       smp_r;
  logic [RANK_BITS-1:0] rank_r;
  logic [AW-1:0]       ws_r;
  logic                full_r;
  logic [MAX_WINDOW-1:0] valid_r;
  logic [S1W-1:0]      s1_r;
  logic [S2W-1:0]      s2_r;
  logic [PW-1:0]       prod_r;
  logic [PW-1:0]       sq_r;
  logic [XW-1:0]       x_r;
  logic [RW:0]         rem_r;
  logic [RW-1:0]       root_r;
  logic [LW-1:0]       drem_r;
  logic [SB-1:0]       rk_r;
  logic [SB-1:0]       mhi_r;
  logic [SB-1:0]       mlo_r;
  logic                ov_r;
  logic                ofull_r;
  logic signed [MEDIAN_BITS-1:0] omed_r;
  logic signed [STD_BITS-1:0]    ostd_r;
  logic [SB-1:0]       orank_r;

  logic [LW-1:0]       n_c;
  logic [SB-1:0]       ram_rdata;
  logic [SB-1:0]       old_c;
  logic [SB-1:0]       key_c;
  logic [AW-1:0]       mhi_idx;
  logic [AW-1:0]       rd_addr;
  logic [SB-1:0]       rd_data;
  logic [S1W-1:0]      mul_a;
  logic [S2W-1:0]      mul_b;
  logic [PW-1:0]       prod_c;
  logic                wrap_c;
  logic [RW+2:0]       rsh_c;
  logic [RW+2:0]       trial_c;
  logic                rge_c;
  logic [LW:0]         dsh_c;
  logic                dge_c;
  logic [DW-1:0]       d_c;
  logic [SB:0]         pair_c;
  logic [SB-1:0]       med_c;

  // effective window length: zero reads as one, clamp to the store depth
  always_comb begin
    if (len_r == '0) begin
      n_c = LW'(1);
    end else if (32'(len_r) > MAX_WINDOW) begin
      n_c = LW'(MAX_WINDOW);
    end else begin
      n_c = LW'(len_r);
    end
  end

  // arrival-order store; never-written slots read as zero
  wms_ram #(.WIDTH(SB), .DEPTH(MAX_WINDOW)) u_ram (
    .clk   (clk),
    .we    (cmd.op == OP_NEW),
    .waddr (ws_r),
    .wdata (smp_r),
    .re    (cmd.ram_rd),
    .raddr (ws_r),
    .rdata (ram_rdata)
  );

  assign old_c  = valid_r[ws_r] ? ram_rdata : '0;
  assign key_c  = (cmd.op == OP_OLD) ? old_c : smp_r;
  assign wrap_c = !(32'(ws_r) + 1 < 32'(n_c));

  // read index into the sorted row
  assign mhi_idx = AW'(n_c >> 1);
  always_comb begin
    case (cmd.op)
      OP_RANK: rd_addr = AW'(rank_r);
      OP_MLO:  rd_addr = n_c[0] ? mhi_idx : mhi_idx - 1'b1;
      default: rd_addr = mhi_idx;
    endcase
  end

  wms_sort_row #(.DEPTH(MAX_WINDOW), .WIDTH(SB)) u_row (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (cfg_we),
    .del_en  (cmd.op == OP_OLD),
    .ins_en  (cmd.op == OP_NEW),
    .key     (key_c),
    .len     (n_c),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // shared multiplier operands: squares of samples, s1 squared, n times s2
  always_comb begin
    case (cmd.op)
      OP_OLD:  begin mul_a = S1W'(old_c); mul_b = S2W'(old_c); end
      OP_NEW:  begin mul_a = S1W'(smp_r); mul_b = S2W'(smp_r); end
      OP_RANK: begin mul_a = s1_r;        mul_b = S2W'(s1_r);  end
      default: begin mul_a = S1W'(n_c);   mul_b = s2_r;        end
    endcase
  end
  assign prod_c = PW'(mul_a) * PW'(mul_b);

  // root step: bring down two radicand bits, try {root, 01}
  assign rsh_c   = {rem_r, x_r[XW-1 -: 2]};
  assign trial_c = (RW + 3)'({root_r, 2'b01});
  assign rge_c   = rsh_c >= trial_c;

  // divide step: bring down one root bit, try the length
  assign dsh_c = {drem_r, root_r[RW-1]};
  assign dge_c = dsh_c >= (LW + 1)'(n_c);

  assign d_c    = DW'(prod_r - sq_r);
  assign pair_c = (SB + 1)'(mhi_r) + (SB + 1)'(mlo_r) + (SB + 1)'(1);
  assign med_c  = n_c[0] ? mhi_r : pair_c[SB:1];

  // request capture and window bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= WINDOW_LEN_RESET;
      ws_r    <= '0;
      full_r  <= 1'b0;
      valid_r <= '0;
      s1_r    <= '0;
      s2_r    <= '0;
    end else if (cfg_we) begin
      len_r   <= cfg_len;
      ws_r    <= '0;
      full_r  <= 1'b0;
      valid_r <= '0;
      s1_r    <= '0;
      s2_r    <= '0;
    end else begin
      case (cmd.op)
        OP_OLD: s1_r <= s1_r - S1W'(old_c);
        OP_NEW: begin
          s1_r          <= s1_r + S1W'(smp_r);
          s2_r          <= s2_r - S2W'(prod_r);
          valid_r[ws_r] <= 1'b1;
          if (wrap_c) begin
            ws_r   <= '0;
            full_r <= 1'b1;
          end else begin
            ws_r <= ws_r + 1'b1;
          end
        end
        OP_ACC: s2_r <= s2_r + S2W'(prod_r);
        default: ;
      endcase
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        req_r  <= in_req_type;
        smp_r  <= in_sample;
        rank_r <= in_rank;
      end
      OP_OLD, OP_NEW: prod_r <= prod_c;
      OP_RANK: begin
        prod_r <= prod_c;
        rk_r   <= (32'(rank_r) < 32'(n_c)) ? rd_data : '0;
      end
      OP_MHI: begin
        sq_r   <= prod_r;
        prod_r <= prod_c;
        mhi_r  <= rd_data;
      end
      OP_MLO: begin
        mlo_r  <= rd_data;
        x_r    <= XW'({d_c, {FRAC_BITS{1'b0}}});
        rem_r  <= '0;
        root_r <= '0;
        drem_r <= '0;
      end
      OP_SQRT: begin
        x_r    <= x_r << 2;
        rem_r  <= rge_c ? (RW + 1)'(rsh_c - trial_c) : (RW + 1)'(rsh_c);
        root_r <= {root_r[RW-2:0], rge_c};
      end
      OP_DIV: begin
        drem_r <= dge_c ? LW'(dsh_c - (LW + 1)'(n_c)) : LW'(dsh_c);
        root_r <= {root_r[RW-2:0], dge_c};
      end
      default: ;
    endcase
  end

  // result register: hold until the result is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      ofull_r <= full_r;
      omed_r  <= full_r ? $signed({1'b0, med_c}) : MEDIAN_NONE;
      ostd_r  <= full_r ? $signed(STD_BITS'(root_r)) : STD_NONE;
      orank_r <= rk_r;
    end
  end

  assign status.is_add   = (req_r == REQ_ADD);
  assign status.full     = full_r;
  assign status.out_busy = ov_r;

  assign out_valid        = ov_r;
  assign out_full_res     = ofull_r;
  assign out_median       = omed_r;
  assign out_std_dev      = ostd_r;
  assign out_ranked_value = orank_r;

  a_slot_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ws_r) < 32'(n_c))
    else $error("write slot beyond window length");

  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_OUT |=> ov_r)
    else $error("result not presented after load");

  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(full_r) |-> $past(cfg_we))
    else $error("full flag dropped without a length write");

endmodule

[design/wms_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wms_ctrl: request sequencer for the window median / std-dev block
// Steps requests through update (adds), read-out, root/divide (full) phases.
// ----------------------------------------------------------------------------
module wms_ctrl #(
  parameter int MAX_WINDOW = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  wms_pkg::dp_status_t status,
  output wms_pkg::dp_cmd_t    cmd
);
  import wms_pkg::*;

  localparam int LW = $clog2(MAX_WINDOW + 1);
  localparam int DW = 2 * SAMPLE_BITS + 2 * LW;
  localparam int RW = (DW + FRAC_BITS + 1) / 2;
  localparam int CW = $clog2(RW);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_OLD  = 10'b0000000010,
    S_NEW  = 10'b0000000100,
    S_ACC  = 10'b0000001000,
    S_C0   = 10'b0000010000,
    S_C1   = 10'b0000100000,
    S_C2   = 10'b0001000000,
    S_SQRT = 10'b0010000000,
    S_DIV  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // next state and command
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    in_ready   = 1'b0;
    cmd.op     = OP_NONE;
    cmd.ram_rd = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          cmd.ram_rd = 1'b1;
          state_nxt  = S_OLD;
        end
      end
      S_OLD: begin
        if (status.is_add) begin
          cmd.op    = OP_OLD;
          state_nxt = S_NEW;
        end else begin
          state_nxt = S_C0;
        end
      end
      S_NEW: begin
        cmd.op    = OP_NEW;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op    = OP_ACC;
        state_nxt = S_C0;
      end
      S_C0: begin
        cmd.op    = OP_RANK;
        state_nxt = S_C1;
      end
      S_C1: begin
        cmd.op    = OP_MHI;
        state_nxt = S_C2;
      end
      S_C2: begin
        cmd.op    = OP_MLO;
        cnt_nxt   = '0;
        state_nxt = status.full ? S_SQRT : S_DONE;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (cnt_r == CW'(RW - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (cnt_r == CW'(RW - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_root_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT || state_r == S_DIV) |-> status.full)
    else $error("root phase entered with window not full");

  a_accept_steps: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_OLD)
    else $error("accepted request not dispatched");

endmodule

[design/window_median_stddev.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_median_stddev: sliding-window median, rank and standard deviation
// Keeps the last window_len samples and answers every request with the full
// flag, median, Q.8 population standard deviation and a ranked sample.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                    request when
//  in_ch    in   req_type, sample, rank                     valid & ready
//  out_ch   out  full_res, median, std_dev, ranked_value    valid & ready
//  cfg_ch   in   window_len                                 valid & ready
//
//  A query runs the read-out states only; an add first updates the store, sums
//  and sorted row. Once the window is full both then run the bit-pair square root
//  and the restoring divide by the length (RW = 26 at MAX_WINDOW 32). One request
//  is in work at a time; the next is taken while a finished result waits in out_ch.
//  Reset and any window_len write clear the window; cfg_ch is always ready.
// ----------------------------------------------------------------------------
module window_median_stddev #(
  parameter int MAX_WINDOW = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  wms_in_if.sink    in_ch,
  wms_out_if.source out_ch,
  wms_cfg_if.sink   cfg_ch
);
  import wms_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       cfg_we;

  // window_len writes are taken at once
  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid;

  wms_ctrl #(.MAX_WINDOW(MAX_WINDOW)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  wms_datapath #(.MAX_WINDOW(MAX_WINDOW)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_len          (cfg_ch.window_len),
    .in_req_type      (in_ch.req_type),
    .in_sample        (in_ch.sample),
    .in_rank          (in_ch.rank),
    .cmd              (cmd),
    .status           (status),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_full_res     (out_ch.full_res),
    .out_median       (out_ch.median),
    .out_std_dev      (out_ch.std_dev),
    .out_ranked_value (out_ch.ranked_value)
  );

endmodule

[test/tb_window_median_stddev.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_window_median_stddev: self-checking bench for window_median_stddev
// Drives add and query requests through the input channel and rewrites the
// window length between phases. A built-in predictor keeps its own window in
// arrival order and computes the full flag, median, Q.8 standard deviation and
// ranked sample for every request. Results are checked in order as they arrive.
// ----------------------------------------------------------------------------
module tb_window_median_stddev;
  import wms_pkg::*;

  typedef struct packed {
    logic                          full_res;
    logic signed [MEDIAN_BITS-1:0] median;
    logic signed [STD_BITS-1:0]    std_dev;
    logic [SAMPLE_BITS-1:0]        ranked_value;
  } stats_t;

  localparam int MAXW        = 32;
  localparam int CYCLE_LIMIT = 1500000;

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   error_count;
  int   results_seen;
  int   idle_pct;
  bit   hold_off;

  wms_in_if  in_ch ();
  wms_out_if out_ch ();
  wms_cfg_if cfg_ch ();

  window_median_stddev u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // predictor state
  logic [SAMPLE_BITS-1:0] win_store [MAXW];
  int                     win_slot;
  bit                     win_full;
  logic [LEN_BITS-1:0]    win_len;
  stats_t                 expected_stats [$];

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("window_median_stddev: mismatch");
      $finish;
    end
  end

  function automatic int active_len();
    if (win_len == 0) begin
      return 1;
    end
    if (win_len > MAXW) begin
      return MAXW;
    end
    return win_len;
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < MAXW; i++) begin
      win_store[i] = '0;
    end
    win_slot = 0;
    win_full = 0;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned a);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > a) begin
      b = b >> 2;
    end
    while (b != 0) begin
      if (a >= res + b) begin
        a = a - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // advance the window with one request and return its statistics
  function automatic stats_t predict_stats(logic rt, logic [11:0] smp, logic [4:0] rk);
    int              n;
    int              j;
    logic [11:0]     srt [MAXW];
    logic [11:0]     v;
    longint unsigned s1;
    longint unsigned s2;
    longint unsigned d;
    stats_t          r;
    n = active_len();
    if (rt == REQ_ADD) begin
      if (win_slot >= n) begin
        win_slot = 0;
      end
      win_store[win_slot] = smp;
      if (win_slot + 1 < n) begin
        win_slot++;
      end else begin
        win_slot = 0;
        win_full = 1;
      end
    end
    for (int i = 0; i < n; i++) begin
      v = win_store[i];
      j = i;
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    if (win_full) begin
      if (n % 2 == 1) begin
        r.median = {1'b0, srt[n/2]};
      end else begin
        r.median = 13'((int'(srt[n/2-1]) + int'(srt[n/2]) + 1) / 2);
      end
      s1 = 0;
      s2 = 0;
      for (int i = 0; i < n; i++) begin
        s1 += win_store[i];
        s2 += longint'(win_store[i]) * win_store[i];
      end
      d = n * s2 - s1 * s1;
      r.std_dev = 20'(int_sqrt(d << 16) / n);
    end else begin
      r.median  = MEDIAN_NONE;
      r.std_dev = STD_NONE;
    end
    r.full_res     = win_full;
    r.ranked_value = (rk < n) ? srt[rk] : '0;
    return r;
  endfunction

  // send one request and record its expectation; valid stays up after the
  // handshake until the next request, an idle cycle or an explicit drop
  task automatic send_request(logic rt, logic [11:0] smp, logic [4:0] rk);
    while (($urandom_range(99) < idle_pct)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= rt;
    in_ch.sample   <= smp;
    in_ch.rank     <= rk;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    expected_stats.push_back(predict_stats(rt, smp, rk));
  endtask

  task automatic wait_drained();
    while (expected_stats.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // write the window length while idle
  task automatic write_length(logic [LEN_BITS-1:0] len);
    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (70) @(posedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.window_len <= len;
    do begin
      @(posedge clk);
    end while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    win_len = len;
    clear_window();
  endtask

  // receiver: random stalls, optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_off && ($urandom_range(99) >= idle_pct);
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    stats_t exp_s;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen <= results_seen + 1;
      if (expected_stats.size() == 0) begin
        $error("result with no request waiting");
        error_count++;
      end else begin
        exp_s = expected_stats.pop_front();
        if (out_ch.full_res !== exp_s.full_res) begin
          $error("full_res: expected %0d actual %0d", exp_s.full_res, out_ch.full_res);
          error_count++;
        end
        if (out_ch.median !== exp_s.median) begin
          $error("median: expected %0d actual %0d", exp_s.median, out_ch.median);
          error_count++;
        end
        if (out_ch.std_dev !== exp_s.std_dev) begin
          $error("std_dev: expected %0d actual %0d", exp_s.std_dev, out_ch.std_dev);
          error_count++;
        end
        if (out_ch.ranked_value !== exp_s.ranked_value) begin
          $error("ranked_value: expected %0d actual %0d", exp_s.ranked_value,
                 out_ch.ranked_value);
          error_count++;
        end
      end
    end
  end

  task automatic test_directed();
    write_length(6'd4);
    send_request(REQ_QUERY, 12'd0, 5'd0);
    send_request(REQ_ADD, 12'hFFF, 5'd31);
    send_request(REQ_ADD, 12'd0, 5'd3);
    send_request(REQ_ADD, 12'h555, 5'd1);
    send_request(REQ_ADD, 12'hAAA, 5'd2);
    send_request(REQ_QUERY, 12'hFFF, 5'd4);
    send_request(REQ_ADD, 12'd1, 5'd0);
    send_request(REQ_ADD, 12'd2, 5'd3);
    // length zero acts as one
    write_length(6'd0);
    send_request(REQ_ADD, 12'd77, 5'd0);
    send_request(REQ_QUERY, 12'd0, 5'd1);
    // length above the maximum acts as the maximum
    write_length(6'd63);
    for (int i = 0; i < 33; i++) begin
      send_request(REQ_ADD, (i % 2) ? 12'hFFF : 12'h000, 5'(i));
    end
    write_length(6'd33);
    send_request(REQ_ADD, 12'd9, 5'd31);
  endtask

  task automatic random_phase(logic [LEN_BITS-1:0] len, int count);
    int rmax;
    write_length(len);
    rmax = (len == 0) ? 0 : (len > 32 ? 31 : len - 1);
    for (int i = 0; i < count; i++) begin
      send_request(($urandom_range(9) == 0) ? REQ_QUERY : REQ_ADD,
                   ($urandom_range(3) == 0) ? 12'($urandom_range(1) * 12'hFFF)
                                            : 12'($urandom),
                   ($urandom_range(7) == 0) ? 5'($urandom) : 5'($urandom_range(rmax)));
    end
  endtask

  task automatic test_random();
    random_phase(6'd1, 80);
    random_phase(6'd2, 100);
    random_phase(6'd3, 100);
    random_phase(6'd32, 250);
    random_phase(6'd7, 150);
    idle_pct = 0;
    random_phase(6'd16, 200);
    idle_pct = 11;
    random_phase(6'($urandom_range(1, 32)), 200);
    random_phase(6'd5, 150);
    random_phase(6'd31, 150);
  endtask

  // receiver holds off while the sender keeps offering, then sender pauses
  task automatic test_backpressure();
    write_length(6'd3);
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      begin
        for (int i = 0; i < 12; i++) begin
          send_request(REQ_ADD, 12'($urandom), 5'($urandom_range(2)));
        end
        in_ch.valid <= 1'b0;
      end
    join
    wait_drained();
    send_request(REQ_QUERY, 12'd0, 5'd2);
  endtask

  initial begin
    rst_n          = 1'b0;
    cycle_count    = 0;
    error_count    = 0;
    results_seen   = 0;
    idle_pct       = 11;
    hold_off       = 0;
    in_ch.valid    = 1'b0;
    in_ch.req_type = REQ_ADD;
    in_ch.sample   = '0;
    in_ch.rank     = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.window_len = WINDOW_LEN_RESET;
    win_len        = WINDOW_LEN_RESET;
    clear_window();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (100) @(posedge clk);
    $display("Checked %0d results over window lengths 0 to 63, adds and queries,",
             results_seen);
    $display("with random stalls on both sides and a long receiver hold-off.");
    if (error_count == 0 && expected_stats.size() == 0) begin
      $display("window_median_stddev: match");
    end else begin
      $display("window_median_stddev: mismatch");
    end
    $finish;
  end

endmodule
